>>> rtl/core/gcct_pkg.sv
// ----------------------------------------------------------------------------
// gcct_pkg
// Shared types, codes and the control store of the grid cell claim table.
// ----------------------------------------------------------------------------
package gcct_pkg;

   // fixed field widths
   localparam int COORD_W    = 6;
   localparam int SIZE_W     = 7;
   localparam int COUNT_W    = 13;
   localparam int AREA_W     = 2 * SIZE_W;
   localparam int STEP_W     = 4;
   localparam int RESET_SIZE = 64;

   typedef logic [STEP_W-1:0] step_type;

   // operation codes of an item
   typedef enum logic [1:0] {
      OP_PICK = 2'd0,
      OP_MARK = 2'd1,
      OP_INIT = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   // cell state codes
   typedef enum logic [1:0] {
      CELL_FREE     = 2'd0,
      CELL_BLOCKED  = 2'd1,
      CELL_EXPLORED = 2'd2,
      CELL_CLAIMED  = 2'd3
   } cell_type;

   // micro-operations, one-hot
   typedef enum logic [5:0] {
      UOP_IDLE     = 6'b000001,
      UOP_DISPATCH = 6'b000010,
      UOP_READ     = 6'b000100,
      UOP_TEST     = 6'b001000,
      UOP_UPDATE   = 6'b010000,
      UOP_FINISH   = 6'b100000
   } uop_type;

   // address source for a cell read
   typedef enum logic [2:0] {
      NBR_SELF  = 3'd0,
      NBR_DOWN  = 3'd1,
      NBR_UP    = 3'd2,
      NBR_RIGHT = 3'd3,
      NBR_LEFT  = 3'd4
   } nbr_type;

   // one control word
   typedef struct packed {
      uop_type  uop;
      nbr_type  nbr;
      step_type next_step;
      step_type jump_step;
   } uword_type;

   // sequencer to datapath
   typedef struct packed {
      uop_type uop;
      nbr_type nbr;
      logic    accept;
   } ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      logic   in_grid;
      logic   nbr_ok;
      logic   cell_free;
      logic   out_free;
      logic   clearing;
      op_type op;
   } stat_type;

   // program addresses
   localparam step_type STEP_IDLE       = 4'd0;
   localparam step_type STEP_DISPATCH   = 4'd1;
   localparam step_type STEP_READ_DOWN  = 4'd2;
   localparam step_type STEP_TEST_DOWN  = 4'd3;
   localparam step_type STEP_READ_UP    = 4'd4;
   localparam step_type STEP_TEST_UP    = 4'd5;
   localparam step_type STEP_READ_RIGHT = 4'd6;
   localparam step_type STEP_TEST_RIGHT = 4'd7;
   localparam step_type STEP_READ_LEFT  = 4'd8;
   localparam step_type STEP_TEST_LEFT  = 4'd9;
   localparam step_type STEP_READ_SELF  = 4'd10;
   localparam step_type STEP_UPDATE     = 4'd11;
   localparam step_type STEP_FINISH     = 4'd12;

   // control store: read moves on to next_step, jumps when the neighbor is off grid;
   // test jumps to finish on a free cell
   function automatic uword_type ucode(step_type s);
      uword_type w;
      case (s)
         STEP_IDLE: begin
            w = '{uop: UOP_IDLE, nbr: NBR_SELF, next_step: STEP_DISPATCH, jump_step: STEP_IDLE};
         end
         STEP_DISPATCH: begin
            w = '{uop: UOP_DISPATCH, nbr: NBR_SELF, next_step: STEP_READ_DOWN,
                  jump_step: STEP_READ_SELF};
         end
         STEP_READ_DOWN: begin
            w = '{uop: UOP_READ, nbr: NBR_DOWN, next_step: STEP_TEST_DOWN,
                  jump_step: STEP_READ_UP};
         end
         STEP_TEST_DOWN: begin
            w = '{uop: UOP_TEST, nbr: NBR_DOWN, next_step: STEP_READ_UP, jump_step: STEP_FINISH};
         end
         STEP_READ_UP: begin
            w = '{uop: UOP_READ, nbr: NBR_UP, next_step: STEP_TEST_UP,
                  jump_step: STEP_READ_RIGHT};
         end
         STEP_TEST_UP: begin
            w = '{uop: UOP_TEST, nbr: NBR_UP, next_step: STEP_READ_RIGHT, jump_step: STEP_FINISH};
         end
         STEP_READ_RIGHT: begin
            w = '{uop: UOP_READ, nbr: NBR_RIGHT, next_step: STEP_TEST_RIGHT,
                  jump_step: STEP_READ_LEFT};
         end
         STEP_TEST_RIGHT: begin
            w = '{uop: UOP_TEST, nbr: NBR_RIGHT, next_step: STEP_READ_LEFT,
                  jump_step: STEP_FINISH};
         end
         STEP_READ_LEFT: begin
            w = '{uop: UOP_READ, nbr: NBR_LEFT, next_step: STEP_TEST_LEFT,
                  jump_step: STEP_FINISH};
         end
         STEP_TEST_LEFT: begin
            w = '{uop: UOP_TEST, nbr: NBR_LEFT, next_step: STEP_FINISH, jump_step: STEP_FINISH};
         end
         STEP_READ_SELF: begin
            w = '{uop: UOP_READ, nbr: NBR_SELF, next_step: STEP_UPDATE, jump_step: STEP_UPDATE};
         end
         STEP_UPDATE: begin
            w = '{uop: UOP_UPDATE, nbr: NBR_SELF, next_step: STEP_FINISH, jump_step: STEP_FINISH};
         end
         STEP_FINISH: begin
            w = '{uop: UOP_FINISH, nbr: NBR_SELF, next_step: STEP_IDLE, jump_step: STEP_FINISH};
         end
         default: begin
            w = '{uop: UOP_IDLE, nbr: NBR_SELF, next_step: STEP_DISPATCH, jump_step: STEP_IDLE};
         end
      endcase
      return w;
   endfunction

endpackage

>>> rtl/core/gcct_seq.sv
// ----------------------------------------------------------------------------
// gcct_seq
// Step counter and control store lookup; picks the next step from the
// current control word and the datapath status.
// ----------------------------------------------------------------------------
module gcct_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  gcct_pkg::stat_type stat,
   output logic              req_stall,
   output gcct_pkg::ctrl_type ctrl
);
   import gcct_pkg::*;

   step_type  step_ff;
   step_type  step_in;
   uword_type word;
   logic      accept;

   // current control word
   assign word = ucode(step_ff);

   // new item only at the idle step and after the clearing pass
   assign req_stall = (word.uop != UOP_IDLE) || stat.clearing;
   assign accept    = req_valid && !req_stall;

   // next step selection
   always_comb begin
      step_in = step_ff;
      case (word.uop)
         UOP_IDLE: begin
            if (accept) step_in = word.next_step;
         end
         UOP_DISPATCH: begin
            if (!stat.in_grid || stat.op == OP_NONE) step_in = STEP_FINISH;
            else if (stat.op == OP_PICK) step_in = word.next_step;
            else step_in = word.jump_step;
         end
         UOP_READ: begin
            step_in = stat.nbr_ok ? word.next_step : word.jump_step;
         end
         UOP_TEST: begin
            step_in = stat.cell_free ? word.jump_step : word.next_step;
         end
         UOP_UPDATE: begin
            step_in = word.next_step;
         end
         UOP_FINISH: begin
            if (stat.out_free) step_in = word.next_step;
         end
         default: begin
            step_in = STEP_IDLE;
         end
      endcase
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // control to datapath
   assign ctrl.uop    = word.uop;
   assign ctrl.nbr    = word.nbr;
   assign ctrl.accept = accept;

endmodule

>>> rtl/core/gcct_dpath.sv
// ----------------------------------------------------------------------------
// gcct_dpath
// Cell memory, neighbor address unit, explored counter and result register.
// ----------------------------------------------------------------------------
module gcct_dpath #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  gcct_pkg::ctrl_type              ctrl,
   output gcct_pkg::stat_type              stat,
   input  logic [1:0]                      req_operation,
   input  logic [gcct_pkg::COORD_W-1:0]    req_row,
   input  logic [gcct_pkg::COORD_W-1:0]    req_col,
   input  logic                            req_init_value,
   input  logic [gcct_pkg::SIZE_W-1:0]     num_rows,
   input  logic [gcct_pkg::SIZE_W-1:0]     num_cols,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_ok,
   output logic [gcct_pkg::COORD_W-1:0]    rsp_next_row,
   output logic [gcct_pkg::COORD_W-1:0]    rsp_next_col,
   output logic [gcct_pkg::COUNT_W-1:0]    rsp_explored_count,
   output logic                            rsp_complete
);
   import gcct_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // cell store
   logic [1:0] cell_mem [DEPTH];

   // latched item
   op_type             op_ff;
   logic [COORD_W-1:0] row_ff;
   logic [COORD_W-1:0] col_ff;
   logic               iv_ff;

   // result being built
   logic               ok_ff;
   logic [COORD_W-1:0] nr_ff;
   logic [COORD_W-1:0] nc_ff;

   // read candidate
   logic [SIZE_W-1:0]  cand_row;
   logic [SIZE_W-1:0]  cand_col;
   logic [IDX_W-1:0]   cand_idx;
   logic               nbr_ok;
   logic [SIZE_W-1:0]  cand_row_ff;
   logic [SIZE_W-1:0]  cand_col_ff;
   logic [IDX_W-1:0]   cand_idx_ff;
   logic [1:0]         rd_data_ff;

   // counter and clearing pass
   logic [COUNT_W-1:0] explored_ff;
   logic               clear_ff;
   logic [IDX_W-1:0]   clear_idx_ff;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_ok_ff;
   logic [COORD_W-1:0] rsp_row_ff;
   logic [COORD_W-1:0] rsp_col_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_complete_ff;

   // misc control
   logic [SIZE_W-1:0]  row7;
   logic [SIZE_W-1:0]  col7;
   logic               in_grid;
   logic               cell_free;
   logic               out_free;
   logic               claim;
   logic               upd_write;
   logic               upd_ok;
   logic [1:0]         upd_data;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [1:0]         mem_wdata;
   logic               mem_re;
   logic [AREA_W-1:0]  area;

   assign row7    = {1'b0, row_ff};
   assign col7    = {1'b0, col_ff};
   assign in_grid = (row7 < num_rows) && (col7 < num_cols);

   // neighbor address and range check
   always_comb begin
      cand_row = row7;
      cand_col = col7;
      nbr_ok   = 1'b0;
      case (ctrl.nbr)
         NBR_SELF: begin
            nbr_ok = 1'b1;
         end
         NBR_DOWN: begin
            cand_row = row7 + 7'd1;
            nbr_ok   = (row7 + 7'd1) < num_rows;
         end
         NBR_UP: begin
            cand_row = row7 - 7'd1;
            nbr_ok   = row_ff != '0;
         end
         NBR_RIGHT: begin
            cand_col = col7 + 7'd1;
            nbr_ok   = (col7 + 7'd1) < num_cols;
         end
         NBR_LEFT: begin
            cand_col = col7 - 7'd1;
            nbr_ok   = col_ff != '0;
         end
         default: begin
            nbr_ok = 1'b0;
         end
      endcase
   end

   assign cand_idx = IDX_W'(int'(cand_row) * MAX_COLS + int'(cand_col));

   // cell update for mark and init
   always_comb begin
      upd_write = 1'b0;
      upd_ok    = 1'b0;
      upd_data  = rd_data_ff;
      case (op_ff)
         OP_MARK: begin
            if (rd_data_ff == CELL_CLAIMED) begin
               upd_write = 1'b1;
               upd_ok    = 1'b1;
               upd_data  = CELL_EXPLORED;
            end else if (rd_data_ff == CELL_EXPLORED) begin
               upd_ok = 1'b1;
            end
         end
         OP_INIT: begin
            if (!iv_ff && rd_data_ff == CELL_FREE) begin
               upd_write = 1'b1;
               upd_ok    = 1'b1;
               upd_data  = CELL_EXPLORED;
            end else if (iv_ff && rd_data_ff == CELL_CLAIMED) begin
               upd_write = 1'b1;
               upd_ok    = 1'b1;
               upd_data  = CELL_BLOCKED;
            end
         end
         default: begin
            upd_write = 1'b0;
         end
      endcase
   end

   assign cell_free = rd_data_ff == CELL_FREE;
   assign claim     = (ctrl.uop == UOP_TEST) && cell_free;

   // memory port select: clearing pass, claim or update
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cand_idx_ff;
      mem_wdata = CELL_CLAIMED;
      if (clear_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clear_idx_ff;
         mem_wdata = CELL_FREE;
      end else if (claim) begin
         mem_we = 1'b1;
      end else if (ctrl.uop == UOP_UPDATE && upd_write) begin
         mem_we    = 1'b1;
         mem_wdata = upd_data;
      end
   end

   assign mem_re = (ctrl.uop == UOP_READ) && nbr_ok;

   always_ff @(posedge clock) begin
      if (mem_we) cell_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= cell_mem[cand_idx];
   end

   // item latch and candidate registers
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         op_ff  <= op_type'(req_operation);
         row_ff <= req_row;
         col_ff <= req_col;
         iv_ff  <= req_init_value;
         nr_ff  <= req_row;
         nc_ff  <= req_col;
         ok_ff  <= 1'b0;
      end else if (claim) begin
         ok_ff <= 1'b1;
         nr_ff <= cand_row_ff[COORD_W-1:0];
         nc_ff <= cand_col_ff[COORD_W-1:0];
      end else if (ctrl.uop == UOP_UPDATE) begin
         ok_ff <= upd_ok;
      end
      if (mem_re) begin
         cand_row_ff <= cand_row;
         cand_col_ff <= cand_col;
         cand_idx_ff <= cand_idx;
      end
   end

   // explored counter, saturating
   always_ff @(posedge clock) begin
      if (reset) begin
         explored_ff <= '0;
      end else if (ctrl.uop == UOP_UPDATE && upd_write && explored_ff != COUNT_MAX) begin
         explored_ff <= explored_ff + 13'd1;
      end
   end

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_idx_ff <= '0;
      end else if (clear_ff) begin
         clear_idx_ff <= clear_idx_ff + IDX_W'(1);
         if (clear_idx_ff == LAST_IDX) clear_ff <= 1'b0;
      end
   end

   // result register
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign area     = AREA_W'(num_rows) * AREA_W'(num_cols);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.uop == UOP_FINISH && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.uop == UOP_FINISH && out_free) begin
         rsp_ok_ff       <= ok_ff;
         rsp_row_ff      <= nr_ff;
         rsp_col_ff      <= nc_ff;
         rsp_count_ff    <= explored_ff;
         rsp_complete_ff <= AREA_W'(explored_ff) == area;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_next_row       = rsp_row_ff;
   assign rsp_next_col       = rsp_col_ff;
   assign rsp_explored_count = rsp_count_ff;
   assign rsp_complete       = rsp_complete_ff;

   // status to sequencer
   assign stat.in_grid   = in_grid;
   assign stat.nbr_ok    = nbr_ok;
   assign stat.cell_free = cell_free;
   assign stat.out_free  = out_free;
   assign stat.clearing  = clear_ff;
   assign stat.op        = op_ff;

`ifndef SYNTHESIS
   // the count never goes down outside reset
   assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (explored_ff >= $past(explored_ff)))
      else $error("explored count decreased");

   // no item is worked on during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.uop != UOP_IDLE) |-> !clear_ff)
      else $error("item in progress during clearing pass");

   // a claimed neighbor lies inside the configured grid
   assert property (@(posedge clock) disable iff (reset)
      claim |-> ((cand_row_ff < num_rows) && (cand_col_ff < num_cols)))
      else $error("claim outside the grid");

   // a result appears only from the finish step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.uop == UOP_FINISH))
      else $error("result loaded outside the finish step");
`endif

endmodule

>>> rtl/core/grid_cell_claim_table.sv
// ----------------------------------------------------------------------------
// grid_cell_claim_table
// Grid of 2-bit cell states with claim, mark and init operations.
// ----------------------------------------------------------------------------
// One item is worked on at a time by a small microcoded sequencer over a
// single-port cell memory (one read or one write a cycle). An item occupies
// the block from acceptance until it can accept again: mark and init pass
// through dispatch, a read of the cell, an update step and finish; a cell
// outside the grid or an unused operation goes from dispatch straight to
// finish; pick-next reads and tests each in-grid neighbor in turn (a memory
// read and a test/write step), skipping off-grid ones, until one is claimed.
// The result sits in an output register, so the next item is taken while it
// waits; the finish step of that next item holds until the waiting result
// is taken. After reset a clearing pass writes every cell free; no item is
// accepted until it ends, but register writes are. num_rows and num_cols
// sit at byte addresses 0 and 4; zero writes are ignored and larger values
// are clamped to MAX_ROWS / MAX_COLS.
module grid_cell_claim_table #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   // item input
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_operation,
   input  logic [gcct_pkg::COORD_W-1:0] req_row,
   input  logic [gcct_pkg::COORD_W-1:0] req_col,
   input  logic                         req_init_value,
   // result output
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_ok,
   output logic [gcct_pkg::COORD_W-1:0] rsp_next_row,
   output logic [gcct_pkg::COORD_W-1:0] rsp_next_col,
   output logic [gcct_pkg::COUNT_W-1:0] rsp_explored_count,
   output logic                         rsp_complete,
   // register port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [2:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import gcct_pkg::*;

   localparam int SIZE_TOP = (1 << SIZE_W) - 1;
   localparam logic [SIZE_W-1:0] ROW_LIMIT = SIZE_W'((MAX_ROWS > SIZE_TOP) ? SIZE_TOP : MAX_ROWS);
   localparam logic [SIZE_W-1:0] COL_LIMIT = SIZE_W'((MAX_COLS > SIZE_TOP) ? SIZE_TOP : MAX_COLS);
   localparam logic [SIZE_W-1:0] ROW_RESET =
      SIZE_W'((MAX_ROWS < RESET_SIZE) ? MAX_ROWS : RESET_SIZE);
   localparam logic [SIZE_W-1:0] COL_RESET =
      SIZE_W'((MAX_COLS < RESET_SIZE) ? MAX_COLS : RESET_SIZE);

   // register index, taken from paddr[2]
   localparam logic REG_NUM_ROWS = 1'b0;
   localparam logic REG_NUM_COLS = 1'b1;

   logic [SIZE_W-1:0] rows_ff;
   logic [SIZE_W-1:0] rows_in;
   logic [SIZE_W-1:0] cols_ff;
   logic [SIZE_W-1:0] cols_in;
   logic [SIZE_W-1:0] wdata;
   logic              csr_wr;
   ctrl_type          ctrl;
   stat_type          stat;

   // register writes, clamped, zero ignored
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign wdata  = pwdata[SIZE_W-1:0];

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_wr && wdata != '0) begin
         if (paddr[2] == REG_NUM_ROWS) rows_in = (wdata > ROW_LIMIT) ? ROW_LIMIT : wdata;
         else cols_in = (wdata > COL_LIMIT) ? COL_LIMIT : wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROW_RESET;
         cols_ff <= COL_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   // register readback
   assign prdata = (paddr[2] == REG_NUM_COLS) ? 32'(cols_ff) : 32'(rows_ff);

   gcct_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .req_stall (req_stall),
      .ctrl      (ctrl)
   );

   gcct_dpath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .stat               (stat),
      .req_operation      (req_operation),
      .req_row            (req_row),
      .req_col            (req_col),
      .req_init_value     (req_init_value),
      .num_rows           (rows_ff),
      .num_cols           (cols_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ok             (rsp_ok),
      .rsp_next_row       (rsp_next_row),
      .rsp_next_col       (rsp_next_col),
      .rsp_explored_count (rsp_explored_count),
      .rsp_complete       (rsp_complete)
   );

endmodule

>>> tb/sv/claim_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// claim_table_checker
// Watches the item, result and register channels of the grid cell claim
// table, keeps its own copy of the grid, the explored count and the grid
// size, predicts the outcome of every accepted item and compares each
// accepted result with the oldest prediction. Register reads are checked
// against the tracked grid size.
// ----------------------------------------------------------------------------
module claim_table_checker #(
   parameter logic [2:0] ROWS_ADDR = 3'd0,
   parameter logic [2:0] COLS_ADDR = 3'd4,
   parameter int         GRID_ROWS = 64,
   parameter int         GRID_COLS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [1:0]                   req_operation,
   input  logic [gcct_pkg::COORD_W-1:0] req_row,
   input  logic [gcct_pkg::COORD_W-1:0] req_col,
   input  logic                         req_init_value,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic                         rsp_ok,
   input  logic [gcct_pkg::COORD_W-1:0] rsp_next_row,
   input  logic [gcct_pkg::COORD_W-1:0] rsp_next_col,
   input  logic [gcct_pkg::COUNT_W-1:0] rsp_explored_count,
   input  logic                         rsp_complete,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [2:0]                   paddr,
   input  logic [31:0]                  pwdata,
   input  logic [31:0]                  prdata,
   input  logic                         pready,
   output int                           fault_count,
   output int                           outstanding
);
   import gcct_pkg::*;

   localparam int PEND_DEPTH = 8;

   typedef struct packed {
      logic               ok;
      logic [COORD_W-1:0] next_row;
      logic [COORD_W-1:0] next_col;
      logic [COUNT_W-1:0] count;
      logic               complete;
   } outcome_type;

   // predictions in a small ring, oldest at head
   outcome_type        outcome_buf [0:PEND_DEPTH-1];
   int                 head = 0;
   int                 pending = 0;
   cell_type           cells [0:GRID_ROWS*GRID_COLS-1];
   logic [COUNT_W-1:0] explored;
   logic [SIZE_W-1:0]  rows_cfg;
   logic [SIZE_W-1:0]  cols_cfg;
   int                 faults = 0;

   assign fault_count = faults;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch in %s: got %0d, want %0d", $time, what, got, want);
      faults++;
   endtask

   // zero keeps the old size, anything above the grid saturates
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [31:0] data,
                                                    input logic [SIZE_W-1:0] keep,
                                                    input int limit);
      logic [SIZE_W-1:0] v;
      v = data[SIZE_W-1:0];
      if (v == '0) return keep;
      if (int'(v) > limit) return SIZE_W'(limit);
      return v;
   endfunction

   function automatic bit claim_if_free(input int r, input int c);
      int idx;
      idx = r * GRID_COLS + c;
      if (cells[idx] == CELL_FREE) begin
         cells[idx] = CELL_CLAIMED;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void count_change();
      if (explored != '1) explored++;
   endfunction

   // applies one item to the tracked grid and returns its outcome
   function automatic outcome_type compute_outcome(input op_type op,
                                                   input logic [COORD_W-1:0] r,
                                                   input logic [COORD_W-1:0] c,
                                                   input logic iv);
      outcome_type o;
      int          ri;
      int          ci;
      int          idx;
      int          nrows;
      int          ncols;
      ri = int'(r);
      ci = int'(c);
      nrows = int'(rows_cfg);
      ncols = int'(cols_cfg);
      o.ok = 1'b0;
      o.next_row = r;
      o.next_col = c;
      if (ri < nrows && ci < ncols) begin
         idx = ri * GRID_COLS + ci;
         case (op)
            OP_PICK: begin
               // neighbors in priority order: down, up, right, left
               if (ri + 1 < nrows && claim_if_free(ri + 1, ci)) begin
                  o.ok = 1'b1;
                  o.next_row = COORD_W'(ri + 1);
               end else if (ri >= 1 && claim_if_free(ri - 1, ci)) begin
                  o.ok = 1'b1;
                  o.next_row = COORD_W'(ri - 1);
               end else if (ci + 1 < ncols && claim_if_free(ri, ci + 1)) begin
                  o.ok = 1'b1;
                  o.next_col = COORD_W'(ci + 1);
               end else if (ci >= 1 && claim_if_free(ri, ci - 1)) begin
                  o.ok = 1'b1;
                  o.next_col = COORD_W'(ci - 1);
               end
            end
            OP_MARK: begin
               if (cells[idx] == CELL_CLAIMED) begin
                  cells[idx] = CELL_EXPLORED;
                  count_change();
                  o.ok = 1'b1;
               end else if (cells[idx] == CELL_EXPLORED) begin
                  o.ok = 1'b1;
               end
            end
            OP_INIT: begin
               if (!iv && cells[idx] == CELL_FREE) begin
                  cells[idx] = CELL_EXPLORED;
                  count_change();
                  o.ok = 1'b1;
               end else if (iv && cells[idx] == CELL_CLAIMED) begin
                  cells[idx] = CELL_BLOCKED;
                  count_change();
                  o.ok = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      o.count = explored;
      o.complete = (int'(explored) == nrows * ncols);
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         foreach (cells[i]) cells[i] = CELL_FREE;
         explored = '0;
         rows_cfg = SIZE_W'(RESET_SIZE);
         cols_cfg = SIZE_W'(RESET_SIZE);
         head = 0;
         pending = 0;
      end else begin
         // register writes and readback
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr == ROWS_ADDR) rows_cfg = clamp_size(pwdata, rows_cfg, GRID_ROWS);
               else if (paddr == COLS_ADDR) cols_cfg = clamp_size(pwdata, cols_cfg, GRID_COLS);
            end else if (paddr == ROWS_ADDR) begin
               if (prdata !== 32'(rows_cfg))
                  report_mismatch("num_rows read", int'(prdata), int'(rows_cfg));
            end else if (paddr == COLS_ADDR) begin
               if (prdata !== 32'(cols_cfg))
                  report_mismatch("num_cols read", int'(prdata), int'(cols_cfg));
            end
         end
         // result channel
         if (rsp_valid && !rsp_stall) begin
            if (pending == 0) begin
               report_mismatch("result with no item pending", 1, 0);
            end else begin
               want = outcome_buf[head];
               head = (head + 1) % PEND_DEPTH;
               pending--;
               if (rsp_ok !== want.ok) report_mismatch("ok", int'(rsp_ok), int'(want.ok));
               if (rsp_next_row !== want.next_row)
                  report_mismatch("next_row", int'(rsp_next_row), int'(want.next_row));
               if (rsp_next_col !== want.next_col)
                  report_mismatch("next_col", int'(rsp_next_col), int'(want.next_col));
               if (rsp_explored_count !== want.count)
                  report_mismatch("explored_count", int'(rsp_explored_count),
                                  int'(want.count));
               if (rsp_complete !== want.complete)
                  report_mismatch("complete", int'(rsp_complete), int'(want.complete));
            end
         end
         // item channel
         if (req_valid && !req_stall) begin
            if (pending == PEND_DEPTH) begin
               report_mismatch("items pending", pending + 1, PEND_DEPTH);
            end else begin
               outcome_buf[(head + pending) % PEND_DEPTH] =
                  compute_outcome(op_type'(req_operation), req_row, req_col, req_init_value);
               pending++;
            end
         end
      end
      outstanding <= pending;
   end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the grid cell claim table.
// ----------------------------------------------------------------------------
// A directed part covers the grid edges, every operation and the corner
// cases of each, then random phases run under different grid sizes with
// exploration walks (pick a neighbor, then mark or block it) mixed with
// bursts of random items. Both channels idle at random; the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
   import gcct_pkg::*;

   localparam logic [2:0] ROWS_ADDR      = 3'd0;
   localparam logic [2:0] COLS_ADDR      = 3'd4;
   localparam int         DIRECTED_ITEMS = 25;
   localparam int         RANDOM_ITEMS   = 450;
   localparam int         PHASE_ITEMS    = 55;
   localparam int         SETTLE_CYCLES  = 16;
   localparam int         RUN_LIMIT_NS   = 5_000_000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_operation = OP_PICK;
   logic [COORD_W-1:0] req_row = '0;
   logic [COORD_W-1:0] req_col = '0;
   logic               req_init_value = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_ok;
   logic [COORD_W-1:0] rsp_next_row;
   logic [COORD_W-1:0] rsp_next_col;
   logic [COUNT_W-1:0] rsp_explored_count;
   logic               rsp_complete;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;
   int                 fault_count;
   int                 outstanding;

   // last accepted result, used to steer exploration walks
   logic               last_ok = 1'b0;
   logic [COORD_W-1:0] last_row = '0;
   logic [COORD_W-1:0] last_col = '0;
   logic [COUNT_W-1:0] last_count = '0;

   bit gaps_on = 1'b1;
   int stall_left = 0;
   int items_sent = 0;
   int rows_now = RESET_SIZE;
   int cols_now = RESET_SIZE;

   grid_cell_claim_table i_dut (.*);

   claim_table_checker #(
      .ROWS_ADDR(ROWS_ADDR),
      .COLS_ADDR(COLS_ADDR)
   ) i_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("simulation failed");
      $finish;
   end

   // mostly short pauses, a few long ones
   function automatic int pause_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= gaps_on && ($urandom_range(0, 2) == 0);
         stall_left <= pause_length();
      end
   end

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         last_ok <= rsp_ok;
         last_row <= rsp_next_row;
         last_col <= rsp_next_col;
         last_count <= rsp_explored_count;
      end
   end

   task automatic send_item(input op_type op, input int r, input int c, input bit iv);
      int gap;
      gap = gaps_on ? pause_length() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_row <= COORD_W'(r);
      req_col <= COORD_W'(c);
      req_init_value <= iv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // stop sending and wait for every pending result
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // size in the low bits, junk above them half the time
   function automatic logic [31:0] size_word(input int size);
      logic [31:0] word;
      word = $urandom();
      word[SIZE_W-1:0] = SIZE_W'(size);
      if ($urandom_range(0, 1) == 0) word = 32'(size);
      return word;
   endfunction

   function automatic int rand_coord(input int limit);
      if ($urandom_range(0, 99) < 85) return $urandom_range(0, limit - 1);
      return $urandom_range(0, 63);
   endfunction

   // seed a cell, then keep claiming neighbors and marking or blocking them
   task automatic explore_walk(input int steps);
      int r;
      int c;
      int roll;
      r = $urandom_range(0, rows_now - 1);
      c = $urandom_range(0, cols_now - 1);
      send_item(OP_INIT, r, c, 1'b0);
      repeat (steps) begin
         send_item(OP_PICK, r, c, 1'($urandom_range(0, 1)));
         wait_drained();
         if (last_ok) begin
            r = int'(last_row);
            c = int'(last_col);
            roll = $urandom_range(0, 99);
            if (roll < 75) send_item(OP_MARK, r, c, 1'($urandom_range(0, 1)));
            else if (roll < 90) send_item(OP_INIT, r, c, 1'b1);
         end else begin
            r = $urandom_range(0, rows_now - 1);
            c = $urandom_range(0, cols_now - 1);
         end
      end
   endtask

   initial begin
      int phase;
      int quota;
      int target;
      int rows_pick;
      logic [31:0] word;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // single-cell grid: every operation, completion and off-grid cases
      csr_access(1'b1, ROWS_ADDR, 32'd1);
      csr_access(1'b1, COLS_ADDR, 32'd1);
      csr_access(1'b0, ROWS_ADDR, '0);
      csr_access(1'b0, COLS_ADDR, '0);
      rows_now = 1;
      cols_now = 1;
      send_item(OP_PICK, 0, 0, 1'b0);
      send_item(OP_INIT, 0, 0, 1'b0);
      send_item(OP_MARK, 0, 0, 1'b1);
      send_item(OP_NONE, 0, 0, 1'b1);
      send_item(OP_INIT, 0, 0, 1'b1);
      send_item(OP_MARK, 63, 63, 1'b0);
      send_item(OP_INIT, 0, 1, 1'b0);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      // oversized rows saturate, zero columns is ignored, then oversized columns
      csr_access(1'b1, ROWS_ADDR, 32'hFFFF_FF7F);
      csr_access(1'b1, COLS_ADDR, 32'h0000_0000);
      csr_access(1'b0, COLS_ADDR, '0);
      csr_access(1'b1, COLS_ADDR, 32'h0000_00C8);
      csr_access(1'b1, COLS_ADDR, 32'd65);
      csr_access(1'b0, ROWS_ADDR, '0);
      csr_access(1'b0, COLS_ADDR, '0);
      rows_now = 64;
      cols_now = 64;

      // corners and all four neighbor directions, then mark and init cases
      send_item(OP_PICK, 63, 63, 1'b1);
      send_item(OP_PICK, 0, 0, 1'b0);
      send_item(OP_PICK, 0, 0, 1'b0);
      send_item(OP_PICK, 0, 0, 1'b0);
      repeat (5) send_item(OP_PICK, 5, 5, 1'b0);
      send_item(OP_MARK, 1, 0, 1'b0);
      send_item(OP_INIT, 0, 1, 1'b1);
      send_item(OP_MARK, 0, 1, 1'b0);
      send_item(OP_MARK, 10, 10, 1'b1);
      send_item(OP_INIT, 0, 1, 1'b0);
      send_item(OP_INIT, 20, 20, 1'b1);
      send_item(OP_INIT, 63, 0, 1'b0);
      send_item(OP_NONE, 63, 63, 1'b1);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      // random phases over several grid shapes
      phase = 0;
      while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         case (phase % 5)
            0: begin
               rows_now = 64;
               cols_now = 64;
            end
            1: begin
               rows_now = 1;
               cols_now = $urandom_range(1, 64);
            end
            2: begin
               rows_now = $urandom_range(1, 64);
               cols_now = 1;
            end
            3: begin
               rows_now = $urandom_range(2, 6);
               cols_now = $urandom_range(2, 6);
            end
            default: begin
               rows_now = $urandom_range(1, 64);
               cols_now = $urandom_range(1, 64);
            end
         endcase
         gaps_on = (phase % 4 != 3);
         if (phase % 5 == 0) begin
            csr_access(1'b1, ROWS_ADDR, size_word($urandom_range(64, 127)));
            csr_access(1'b1, COLS_ADDR, size_word($urandom_range(64, 127)));
         end else begin
            csr_access(1'b1, COLS_ADDR, size_word(cols_now));
            csr_access(1'b1, ROWS_ADDR, size_word(rows_now));
         end
         // a write with zero size bits leaves the register alone
         if ($urandom_range(0, 2) == 0) begin
            word = $urandom();
            word[SIZE_W-1:0] = '0;
            csr_access(1'b1, ROWS_ADDR, word);
         end
         csr_access(1'b0, ROWS_ADDR, '0);
         csr_access(1'b0, COLS_ADDR, '0);
         quota = items_sent + PHASE_ITEMS;
         while (items_sent < quota) begin
            if ($urandom_range(0, 9) < 6) begin
               explore_walk($urandom_range(2, 8));
            end else begin
               repeat ($urandom_range(3, 12)) begin
                  send_item(op_type'($urandom_range(0, 3)), rand_coord(rows_now),
                            rand_coord(cols_now), 1'($urandom_range(0, 1)));
               end
            end
         end
         wait_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
         phase++;
      end

      // size the grid to the explored count so that results report completion
      gaps_on = 1'b1;
      target = int'(last_count);
      rows_pick = 0;
      for (int d = 1; d <= 64; d++) begin
         if (rows_pick == 0 && target != 0 && target % d == 0 && target / d <= 64) begin
            rows_pick = d;
         end
      end
      if (rows_pick != 0) begin
         csr_access(1'b1, ROWS_ADDR, 32'(rows_pick));
         csr_access(1'b1, COLS_ADDR, 32'(target / rows_pick));
         repeat (4) send_item(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                              1'($urandom_range(0, 1)));
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/gcct_pkg.sv
rtl/core/gcct_seq.sv
rtl/core/gcct_dpath.sv
rtl/core/grid_cell_claim_table.sv
tb/sv/claim_table_checker.sv
tb/sv/testbench.sv
